### rtl/core/imu_rs_pkg.sv
// Shared types and constants for the IMU accel-to-gyro time resampler.
// No dependencies; the interpolation unit and the top level refer to it by scoped names.

package imu_rs_pkg;

  // Number of axes carried by each sample
  localparam int unsigned AxisCount = 3;

  // Status of the shared interpolation unit, seen by the sequencer
  typedef struct packed {
    logic busy;  // unit is iterating or rounding
    logic done;  // one-cycle pulse: result_o holds a finished axis
  } iu_stat_t;

endpackage

### rtl/core/imu_rs_if.sv
// Valid/ready channel interfaces: IMU events in, fused records out.
// Depends on nothing; widths come from the instance parameters.

interface imu_rs_evt_if #(
  parameter int unsigned TIME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic        [TIME_BITS-1:0]   stamp_us;
  logic signed [SAMPLE_BITS-1:0] axis_x;
  logic signed [SAMPLE_BITS-1:0] axis_y;
  logic signed [SAMPLE_BITS-1:0] axis_z;

  modport source (output valid, kind, stamp_us, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, kind, stamp_us, axis_x, axis_y, axis_z, output ready);
endinterface

interface imu_rs_rec_if #(
  parameter int unsigned TIME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic        [TIME_BITS-1:0]   fused_time_us;
  logic signed [SAMPLE_BITS-1:0] acc_x;
  logic signed [SAMPLE_BITS-1:0] acc_y;
  logic signed [SAMPLE_BITS-1:0] acc_z;
  logic signed [SAMPLE_BITS-1:0] rate_x;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, fused_time_us, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink   (input valid, fused_time_us, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

### rtl/core/imu_rs_interp_unit.sv
// Shared interpolation unit: ap + round(|an-ap| * w / den) with the sign of an-ap.
// Uses imu_rs_pkg::iu_stat_t. One magnitude bit per cycle, then a single rounding state.

module imu_rs_interp_unit #(
  parameter int unsigned TIME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] ap_i,
  input  logic signed [SAMPLE_BITS-1:0] an_i,
  input  logic        [TIME_BITS-1:0]   w_i,
  input  logic        [TIME_BITS-1:0]   den_i,
  output imu_rs_pkg::iu_stat_t          stat_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int unsigned MagBits = SAMPLE_BITS + 1;
  localparam int unsigned CntBits = $clog2(MagBits);
  localparam int unsigned AccBits = TIME_BITS + 2;
  localparam int unsigned SumBits = SAMPLE_BITS + 2;
  localparam logic [CntBits-1:0] LastStep = CntBits'(MagBits - 1);

  typedef enum logic [2:0] {
    UIdle = 3'b001,
    URun  = 3'b010,
    UFin  = 3'b100
  } unit_state_e;

  unit_state_e                   state_q, state_d;
  logic        [CntBits-1:0]     cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic        [MagBits-1:0]     mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic signed [SAMPLE_BITS-1:0] ap_q, ap_d;
  logic        [TIME_BITS-1:0]   w_q, w_d;
  logic        [TIME_BITS-1:0]   den_q, den_d;
  logic        [TIME_BITS-1:0]   r_q, r_d;
  logic        [MagBits-1:0]     quo_q, quo_d;
  logic signed [SAMPLE_BITS-1:0] result_q, result_d;

  logic [MagBits-1:0] diff, mag_abs;
  logic [AccBits-1:0] acc2, den1, den2, rem_n;
  logic [1:0]         dig;
  logic [TIME_BITS:0] twice_r, den_e;
  logic               inc;
  logic [SumBits-1:0] qr, ap_e, sum;

  // Difference of the two samples, split into sign and magnitude
  assign diff    = {an_i[SAMPLE_BITS-1], an_i} - {ap_i[SAMPLE_BITS-1], ap_i};
  assign mag_abs = diff[MagBits-1] ? (~diff + MagBits'(1)) : diff;

  // Fused multiply-divide step: r <- 2r + bit*w, reduce by den or 2*den
  always_comb begin
    acc2 = {1'b0, r_q, 1'b0} + (mag_q[MagBits-1] ? {2'b00, w_q} : '0);
    den1 = {2'b00, den_q};
    den2 = {1'b0, den_q, 1'b0};
    if (acc2 >= den2) begin
      rem_n = acc2 - den2;
      dig   = 2'd2;
    end else if (acc2 >= den1) begin
      rem_n = acc2 - den1;
      dig   = 2'd1;
    end else begin
      rem_n = acc2;
      dig   = 2'd0;
    end
  end

  // Round to nearest, ties toward plus infinity, then apply to ap
  always_comb begin
    twice_r = {r_q, 1'b0};
    den_e   = {1'b0, den_q};
    inc     = neg_q ? (twice_r > den_e) : (twice_r >= den_e);
    qr      = {1'b0, quo_q} + SumBits'(inc);
    ap_e    = {{2{ap_q[SAMPLE_BITS-1]}}, ap_q};
    sum     = neg_q ? (ap_e - qr) : (ap_e + qr);
  end

  // Sequence load, iterate and finish
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    mag_d    = mag_q;
    neg_d    = neg_q;
    ap_d     = ap_q;
    w_d      = w_q;
    den_d    = den_q;
    r_d      = r_q;
    quo_d    = quo_q;
    result_d = result_q;
    case (state_q)
      UIdle: begin
        if (start_i) begin
          mag_d   = mag_abs;
          neg_d   = diff[MagBits-1];
          ap_d    = ap_i;
          w_d     = w_i;
          den_d   = den_i;
          r_d     = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = URun;
        end
      end
      URun: begin
        mag_d = {mag_q[MagBits-2:0], 1'b0};
        r_d   = rem_n[TIME_BITS-1:0];
        quo_d = {quo_q[MagBits-2:0], 1'b0} + MagBits'(dig);
        cnt_d = cnt_q + CntBits'(1);
        if (cnt_q == LastStep) begin
          state_d = UFin;
        end
      end
      UFin: begin
        result_d = sum[SAMPLE_BITS-1:0];
        done_d   = 1'b1;
        state_d  = UIdle;
      end
      default: begin
        state_d = UIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    ap_q     <= ap_d;
    w_q      <= w_d;
    den_q    <= den_d;
    r_q      <= r_d;
    quo_q    <= quo_d;
    result_q <= result_d;
  end

  assign stat_o.busy = (state_q != UIdle);
  assign stat_o.done = done_q;
  assign result_o    = result_q;

endmodule

### rtl/core/imu_accel_to_gyro_time_resampler.sv
// Top level of the IMU accel-to-gyro time resampler: event decode, sample state,
// axis sequencer and output register. Uses imu_rs_pkg, imu_rs_if.sv, imu_rs_interp_unit.
//
//   channel | dir | handshake   | payload
//   evt_i   | in  | valid/ready | kind, stamp_us, axis_x/y/z
//   rec_o   | out | valid/ready | fused_time_us, acc_x/y/z, rate_x/y/z
//
// A gyro event, or an accel event that makes no record, is handled in the idle state.
// An accel event that makes a record goes through start and run for each axis, then push:
// the one interpolation unit resolves one magnitude bit per cycle, axis after axis.
// Reset clears all sample state and the output valid flag at once; no clearing pass.
// A stalled record waits in the output register while further events are taken;
// a new record waits in its push state until that register is free.

module imu_accel_to_gyro_time_resampler #(
  parameter int unsigned TIME_BITS   = 40,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imu_rs_evt_if.sink   evt_i,
  imu_rs_rec_if.source rec_o
);

  localparam int unsigned Axes = imu_rs_pkg::AxisCount;
  localparam logic [1:0] LastAxis = 2'(Axes - 1);
  localparam logic KindAccel = 1'b0;
  localparam logic KindGyro  = 1'b1;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StStart = 4'b0010,
    StRun   = 4'b0100,
    StPush  = 4'b1000
  } seq_state_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  seq_state_e           state_q, state_d;
  logic [1:0]           idx_q, idx_d;
  logic [TIME_BITS-1:0] gyro_q, gyro_d;
  logic [TIME_BITS-1:0] accel_q, accel_d;
  logic [TIME_BITS-1:0] t_new_q, t_new_d;
  logic [TIME_BITS-1:0] w_q, w_d;
  logic [TIME_BITS-1:0] den_q, den_d;
  sample_t              prev_q [Axes];
  sample_t              prev_d [Axes];
  sample_t              rate_q [Axes];
  sample_t              rate_d [Axes];
  sample_t              new_q  [Axes];
  sample_t              new_d  [Axes];
  sample_t              res_q  [Axes];
  sample_t              res_d  [Axes];
  sample_t              axes_in [Axes];

  logic                 out_valid_q, out_valid_d;
  logic [TIME_BITS-1:0] out_time_q, out_time_d;
  sample_t              out_acc_q  [Axes];
  sample_t              out_acc_d  [Axes];
  sample_t              out_rate_q [Axes];
  sample_t              out_rate_d [Axes];

  logic                 in_xfer;
  logic                 fuse;
  logic                 out_free;
  logic                 start;
  imu_rs_pkg::iu_stat_t iu_stat;
  sample_t              iu_result;

  assign axes_in[0] = evt_i.axis_x;
  assign axes_in[1] = evt_i.axis_y;
  assign axes_in[2] = evt_i.axis_z;

  assign evt_i.ready = (state_q == StIdle);
  assign in_xfer     = evt_i.valid && evt_i.ready;
  assign out_free    = !out_valid_q || rec_o.ready;

  // Record needed: gyro seen, accel at or after it, held accel older than it
  assign fuse = (evt_i.kind == KindAccel) && (gyro_q != '0) &&
                (evt_i.stamp_us >= gyro_q) && (accel_q < gyro_q);

  // Decode events, step through the three axes and push the record
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    gyro_d      = gyro_q;
    accel_d     = accel_q;
    t_new_d     = t_new_q;
    w_d         = w_q;
    den_d       = den_q;
    prev_d      = prev_q;
    rate_d      = rate_q;
    new_d       = new_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !rec_o.ready;
    out_time_d  = out_time_q;
    out_acc_d   = out_acc_q;
    out_rate_d  = out_rate_q;
    start       = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (evt_i.kind == KindGyro) begin
            gyro_d = evt_i.stamp_us;
            rate_d = axes_in;
          end else if (fuse) begin
            new_d   = axes_in;
            t_new_d = evt_i.stamp_us;
            w_d     = gyro_q - accel_q;
            den_d   = evt_i.stamp_us - accel_q;
            idx_d   = '0;
            state_d = StStart;
          end else begin
            accel_d = evt_i.stamp_us;
            prev_d  = axes_in;
          end
        end
      end
      StStart: begin
        start   = 1'b1;
        state_d = StRun;
      end
      StRun: begin
        if (iu_stat.done) begin
          res_d[idx_q] = iu_result;
          if (idx_q == LastAxis) begin
            state_d = StPush;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = StStart;
          end
        end
      end
      StPush: begin
        // Load the record once the output register frees, then commit the accel
        if (out_free) begin
          out_valid_d = 1'b1;
          out_time_d  = gyro_q;
          out_acc_d   = res_q;
          out_rate_d  = rate_q;
          prev_d      = new_q;
          accel_d     = t_new_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      gyro_q      <= '0;
      accel_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Axes; i++) begin
        prev_q[i] <= '0;
        rate_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      gyro_q      <= gyro_d;
      accel_q     <= accel_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      rate_q      <= rate_d;
    end
  end

  // Working and output payload registers need no reset
  always_ff @(posedge clk_i) begin
    t_new_q    <= t_new_d;
    w_q        <= w_d;
    den_q      <= den_d;
    new_q      <= new_d;
    res_q      <= res_d;
    out_time_q <= out_time_d;
    out_acc_q  <= out_acc_d;
    out_rate_q <= out_rate_d;
  end

  imu_rs_interp_unit #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ap_i    (prev_q[idx_q]),
    .an_i    (new_q[idx_q]),
    .w_i     (w_q),
    .den_i   (den_q),
    .stat_o  (iu_stat),
    .result_o(iu_result)
  );

  assign rec_o.valid         = out_valid_q;
  assign rec_o.fused_time_us = out_time_q;
  assign rec_o.acc_x         = out_acc_q[0];
  assign rec_o.acc_y         = out_acc_q[1];
  assign rec_o.acc_z         = out_acc_q[2];
  assign rec_o.rate_x        = out_rate_q[0];
  assign rec_o.rate_y        = out_rate_q[1];
  assign rec_o.rate_z        = out_rate_q[2];

  // A unit result only arrives while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iu_stat.done |-> (state_q == StRun))
    else $error("interpolation result outside run state");

  // The unit is never started while still busy
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !iu_stat.busy)
    else $error("interpolation unit started while busy");

  // Leaving the push state always presents a record
  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush && out_free) |=> (rec_o.valid && state_q == StIdle))
    else $error("push did not load the output register");

  // A record is only ever aligned to a real gyro time
  a_time_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_o.valid |-> (rec_o.fused_time_us != '0))
    else $error("record with zero gyro time");

endmodule

### test/imu_accel_to_gyro_time_resampler_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the accel-to-gyro time resampler: directed and random IMU events,
// a local interpolation predictor and an in-order compare of fused records.
// Depends on imu_rs_pkg, imu_rs_if.sv and the resampler RTL.

module imu_accel_to_gyro_time_resampler_test;

  localparam int unsigned TB    = 40;
  localparam int unsigned SB    = 32;
  localparam int unsigned AXES  = imu_rs_pkg::AxisCount;

  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  localparam logic [SB-1:0] MAXV = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] MINV = {1'b1, {(SB-1){1'b0}}};
  localparam logic [TB-1:0] MAXT = {TB{1'b1}};

  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES  = 250;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 500;

  typedef struct packed {
    logic                     kind;
    logic [TB-1:0]            stamp;
    logic [AXES-1:0][SB-1:0]  axis;
  } imu_evt_t;

  typedef struct packed {
    logic [TB-1:0]            time_us;
    logic [AXES-1:0][SB-1:0]  acc;
    logic [AXES-1:0][SB-1:0]  rate;
  } fused_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  imu_rs_evt_if #(.TIME_BITS(TB), .SAMPLE_BITS(SB)) evt_if ();
  imu_rs_rec_if #(.TIME_BITS(TB), .SAMPLE_BITS(SB)) rec_if ();

  imu_accel_to_gyro_time_resampler #(
    .TIME_BITS  (TB),
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_if),
    .rec_o (rec_if)
  );

  always #5 clk_i = ~clk_i;

  // Pending events, records due, and the predictor's copy of the sample state
  imu_evt_t                 imu_evt_q[$];
  fused_rec_t               fused_due_q[$];
  logic [TB-1:0]            gyro_stamp_q;
  logic [TB-1:0]            accel_stamp_q;
  logic [AXES-1:0][SB-1:0]  held_acc_q;
  logic [AXES-1:0][SB-1:0]  gyro_rate_q;

  int            tx_idle_pct;
  int            rx_idle_pct;
  int            n_accepted;
  int            n_miss;
  int            cycle_cnt;
  int            hold_left;
  logic          hold_done;
  logic [TB-1:0] gen_t;

  // Interpolate one axis to the gyro time, rounding to nearest with ties upward
  function automatic logic [SB-1:0] lerp_axis(logic [SB-1:0] a_old, logic [SB-1:0] a_new,
                                              logic [TB-1:0] w, logic [TB-1:0] den);
    logic signed [SB+1:0] diff;
    logic [SB+1:0]        mag;
    logic                 neg;
    logic [127:0]         mag_w, w_w, den_w, prod, quo, rem;
    diff  = (SB+2)'($signed(a_new)) - (SB+2)'($signed(a_old));
    neg   = diff[SB+1];
    mag   = neg ? -diff : diff;
    mag_w = 128'(mag);
    w_w   = 128'(w);
    den_w = 128'(den);
    prod  = mag_w * w_w;
    quo   = prod / den_w;
    rem   = prod % den_w;
    if (neg) begin
      if (rem > den_w - rem) quo = quo + 128'd1;
      return a_old - quo[SB-1:0];
    end
    if (rem >= den_w - rem) quo = quo + 128'd1;
    return a_old + quo[SB-1:0];
  endfunction

  // Advance the sample state by one accepted event; queue the record it makes
  function automatic void resample_event(imu_evt_t e);
    fused_rec_t r;
    if (e.kind == KIND_GYRO) begin
      gyro_rate_q  = e.axis;
      gyro_stamp_q = e.stamp;
    end else begin
      if (gyro_stamp_q != 0 && e.stamp >= gyro_stamp_q && accel_stamp_q < gyro_stamp_q) begin
        r.time_us = gyro_stamp_q;
        r.rate    = gyro_rate_q;
        for (int i = 0; i < AXES; i++)
          r.acc[i] = lerp_axis(held_acc_q[i], e.axis[i], gyro_stamp_q - accel_stamp_q,
                               e.stamp - accel_stamp_q);
        fused_due_q = {fused_due_q, r};
      end
      accel_stamp_q = e.stamp;
      held_acc_q    = e.axis;
    end
  endfunction

  function automatic void push_evt(logic kind, logic [TB-1:0] stamp,
                                   logic [SB-1:0] x, logic [SB-1:0] y, logic [SB-1:0] z);
    imu_evt_t e;
    e.kind  = kind;
    e.stamp = stamp;
    e.axis  = {z, y, x};
    imu_evt_q = {imu_evt_q, e};
  endfunction

  function automatic logic [SB-1:0] rand_axis();
    case ($urandom_range(9))
      0:       return MAXV;
      1:       return MINV;
      2:       return SB'($urandom_range(255)) - SB'(128);
      default: return SB'($urandom);
    endcase
  endfunction

  // Mostly a time-ordered mix of both sources, with some events at random stamps
  function automatic imu_evt_t rand_event();
    imu_evt_t e;
    int       sel;
    e.kind = 1'($urandom_range(1));
    for (int i = 0; i < AXES; i++) e.axis[i] = rand_axis();
    if ($urandom_range(99) < 8) begin
      e.stamp = TB'({$urandom, $urandom});
      return e;
    end
    sel = $urandom_range(99);
    if (sel < 10)      gen_t = gen_t;
    else if (sel < 85) gen_t = gen_t + TB'($urandom_range(2000, 1));
    else if (sel < 97) gen_t = gen_t + TB'($urandom_range(1000000, 2001));
    else               gen_t = gen_t + TB'({$urandom_range(63, 0), $urandom});
    e.stamp = gen_t;
    return e;
  endfunction

  function automatic void note_miss(string what, logic [63:0] want, logic [63:0] got);
    n_miss++;
    if (n_miss <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  // Driver: predict on each accepted transfer, then offer the next event or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_if.valid    <= 1'b0;
      evt_if.kind     <= KIND_ACCEL;
      evt_if.stamp_us <= '0;
      evt_if.axis_x   <= '0;
      evt_if.axis_y   <= '0;
      evt_if.axis_z   <= '0;
      n_accepted      <= 0;
      gyro_stamp_q    = '0;
      accel_stamp_q   = '0;
      held_acc_q      = '0;
      gyro_rate_q     = '0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        resample_event({evt_if.kind, evt_if.stamp_us, evt_if.axis_z, evt_if.axis_y,
                        evt_if.axis_x});
        n_accepted <= n_accepted + 1;
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (imu_evt_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          imu_evt_t e;
          e = imu_evt_q.pop_front();
          evt_if.valid    <= 1'b1;
          evt_if.kind     <= e.kind;
          evt_if.stamp_us <= e.stamp;
          evt_if.axis_x   <= e.axis[0];
          evt_if.axis_y   <= e.axis[1];
          evt_if.axis_z   <= e.axis[2];
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver once for a long stretch so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each record transfer with the oldest record due
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_if.ready <= 1'b0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        fused_rec_t want;
        fused_rec_t got;
        got.time_us = rec_if.fused_time_us;
        got.acc     = {rec_if.acc_z, rec_if.acc_y, rec_if.acc_x};
        got.rate    = {rec_if.rate_z, rec_if.rate_y, rec_if.rate_x};
        if (fused_due_q.size() == 0) begin
          note_miss("unexpected record time", '0, 64'(got.time_us));
        end else begin
          want = fused_due_q.pop_front();
          if (got.time_us !== want.time_us)
            note_miss("fused_time_us", 64'(want.time_us), 64'(got.time_us));
          for (int i = 0; i < AXES; i++) begin
            if (got.acc[i] !== want.acc[i])
              note_miss($sformatf("acc axis %0d", i), 64'(want.acc[i]), 64'(got.acc[i]));
            if (got.rate[i] !== want.rate[i])
              note_miss($sformatf("rate axis %0d", i), 64'(want.rate[i]), 64'(got.rate[i]));
          end
        end
      end
      rec_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Wait until every event is transferred and every record has come back
  task automatic drain_all();
    while (imu_evt_q.size() != 0 || evt_if.valid || fused_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    tx_idle_pct     = 32;
    rx_idle_pct     = 61;
    gen_t           = TB'(30);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First accel after reset interpolates from the zero sample at time zero
    push_evt(KIND_GYRO,  50, MAXV, MINV, 0);
    push_evt(KIND_ACCEL, 80, SB'(32'h0001_0000), SB'(32'hFFFF_0000), MAXV);
    // Gyro at stamp zero counts as no gyro: accel only held
    push_evt(KIND_GYRO,  0, 1, 2, 3);
    push_evt(KIND_ACCEL, 90, 5, 6, 7);
    // Accel before gyro time is held, the next one swings across the full range
    push_evt(KIND_GYRO,  300, MINV, MAXV, SB'(-1));
    push_evt(KIND_ACCEL, 250, MINV, MAXV, 12345);
    push_evt(KIND_ACCEL, 400, MAXV, MINV, 0);
    // Held accel already newer than the gyro time
    push_evt(KIND_ACCEL, 500, 9, 9, 9);
    // Equal stamps give the new accel exactly
    push_evt(KIND_GYRO,  600, 10, 20, 30);
    push_evt(KIND_ACCEL, 600, 7, SB'(-7), MAXV);
    // Half-way ties, both directions
    push_evt(KIND_GYRO,  700, MAXV, MAXV, MAXV);
    push_evt(KIND_ACCEL, 800, 8, SB'(-8), MINV);
    push_evt(KIND_GYRO,  1000, 1, SB'(-1), 0);
    push_evt(KIND_ACCEL, 1003, MINV, MINV, MINV);
    // Stamps at the top of the range
    push_evt(KIND_GYRO,  MAXT - 1, MAXV, MAXV, MAXV);
    push_evt(KIND_ACCEL, MAXT, MAXV, 0, MINV);
    push_evt(KIND_GYRO,  MAXT, 0, 0, 0);
    push_evt(KIND_ACCEL, MAXT, 1, 1, 1);
    // Stamps going backward
    push_evt(KIND_GYRO,  5, MAXV, MINV, 1);
    push_evt(KIND_ACCEL, 10, SB'(-5), 5, 0);
    push_evt(KIND_GYRO,  20, 4, 5, 6);
    push_evt(KIND_ACCEL, 30, 100, SB'(-100), MAXV);

    repeat (320) imu_evt_q = {imu_evt_q, rand_event()};
    drain_all();

    tx_idle_pct = 61;
    rx_idle_pct = 32;
    repeat (320) imu_evt_q = {imu_evt_q, rand_event()};
    drain_all();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (310) imu_evt_q = {imu_evt_q, rand_event()};
    drain_all();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_miss == 0 && fused_due_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/imu_rs_pkg.sv
rtl/core/imu_rs_if.sv
rtl/core/imu_rs_interp_unit.sv
rtl/core/imu_accel_to_gyro_time_resampler.sv
test/imu_accel_to_gyro_time_resampler_test.sv
